FILE: design/btmx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package btmx_pkg;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_DONE
  } state_e;

  localparam int unsigned KeyFieldBits = 40;

endpackage
`default_nettype wire

FILE: design/btmx_level_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One bit of the walk: holds a key bit and hands the key bit onwards each step.
module btmx_level_cell
  import btmx_pkg::*;
(
  input  wire  clk_i,
  input  wire  load_i,
  input  wire  shift_i,
  input  wire  load_bit_i,
  input  wire  prev_bit_i,
  output logic bit_o
);

  logic bit_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bit_q <= load_bit_i;
    end else if (shift_i) begin
      bit_q <= prev_bit_i;
    end
  end

  assign bit_o = bit_q;

endmodule
`default_nettype wire

FILE: design/btmx_walker.sv
`timescale 1ns / 1ps
`default_nettype none
module btmx_walker
  import btmx_pkg::*;
#(
  parameter int unsigned KEY_BITS  = 40,
  parameter int unsigned MAX_NODES = 4096
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire                  action_i,
  input  wire                  top_bit_i,
  output logic                 shift_o,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [KEY_BITS-1:0]  best_o,
  output status_e              status_o,
  input  wire                  take_i
);

  localparam int unsigned IdxW = $clog2(MAX_NODES);
  localparam int unsigned CntW = $clog2(MAX_NODES + 1);
  localparam int unsigned LvlW = $clog2(KEY_BITS + 1);

  logic [2*IdxW-1:0] mem [MAX_NODES];
  logic [2*IdxW-1:0] rd_q;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [2*IdxW-1:0] wr_data;
  logic              root_init_q;

  state_e state_q, state_d;
  logic [LvlW-1:0]     lvl_q, lvl_d;
  logic [IdxW-1:0]     node_q, node_d;
  logic [CntW-1:0]     used_q, used_d;
  logic                nonempty_q, nonempty_d;
  logic                act_q, act_d;
  logic [KEY_BITS-1:0] best_q, best_d;
  logic [KEY_BITS-1:0] mask_q, mask_d;
  status_e             stat_q, stat_d;

  logic [2*IdxW-1:0] rd_eff;
  logic [IdxW-1:0]   c0, c1, csame, copp, fresh;
  logic [LvlW-1:0]   need;
  logic              last_lvl, leaf, no_room;

  // The root entry reads as empty until it is first written after reset.
  assign rd_eff   = (node_q == '0 && !root_init_q) ? '0 : rd_q;
  assign c0       = rd_eff[IdxW-1:0];
  assign c1       = rd_eff[2*IdxW-1:IdxW];
  assign csame    = top_bit_i ? c1 : c0;
  assign copp     = top_bit_i ? c0 : c1;
  assign fresh    = used_q[IdxW-1:0];
  assign need     = LvlW'(KEY_BITS) - lvl_q;
  assign no_room  = ({1'b0, used_q} + (CntW+1)'(need)) > (CntW+1)'(MAX_NODES);
  assign last_lvl = lvl_q == LvlW'(KEY_BITS - 1);
  assign leaf     = lvl_q == LvlW'(KEY_BITS);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[node_q] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= CntW'(1);
      nonempty_q  <= 1'b0;
      root_init_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      nonempty_q <= nonempty_d;
      if (wr_en && node_q == '0) begin
        root_init_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q  <= lvl_d;
    node_q <= node_d;
    act_q  <= act_d;
    best_q <= best_d;
    mask_q <= mask_d;
    stat_q <= stat_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (action_i && !nonempty_q) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (act_q) begin
          if (last_lvl || (copp == '0 && csame == '0)) begin
            state_d = ST_DONE;
          end
        end else if (csame == '0) begin
          state_d = no_room ? ST_DONE : ST_ALLOC;
        end else if (last_lvl) begin
          state_d = ST_DONE;
        end
      end
      ST_ALLOC: begin
        if (leaf) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    lvl_d      = lvl_q;
    node_d     = node_q;
    act_d      = act_q;
    best_d     = best_q;
    mask_d     = mask_q;
    stat_d     = stat_q;
    used_d     = used_q;
    nonempty_d = nonempty_q;
    rd_addr    = node_q;
    wr_en      = 1'b0;
    wr_data    = '0;
    shift_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        lvl_d   = '0;
        node_d  = '0;
        act_d   = action_i;
        best_d  = '0;
        mask_d  = {1'b1, {(KEY_BITS-1){1'b0}}};
        stat_d  = (action_i && !nonempty_q) ? STATUS_EMPTY : STATUS_OK;
        rd_addr = '0;
      end
      ST_WALK: begin
        if (act_q) begin
          if (copp != '0) begin
            best_d = best_q | mask_q;
            node_d = copp;
          end else begin
            node_d = csame;
          end
          if (!last_lvl && (copp != '0 || csame != '0)) begin
            rd_addr = node_d;
            lvl_d   = lvl_q + LvlW'(1);
            mask_d  = mask_q >> 1;
            shift_o = 1'b1;
          end
        end else if (csame == '0) begin
          if (no_room) begin
            stat_d = STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_data = top_bit_i ? {fresh, c0} : {c1, fresh};
            node_d  = fresh;
            used_d  = used_q + CntW'(1);
            lvl_d   = lvl_q + LvlW'(1);
            shift_o = 1'b1;
          end
        end else if (last_lvl) begin
          nonempty_d = 1'b1;
        end else begin
          node_d  = csame;
          rd_addr = csame;
          lvl_d   = lvl_q + LvlW'(1);
          shift_o = 1'b1;
        end
      end
      ST_ALLOC: begin
        wr_en = 1'b1;
        if (leaf) begin
          wr_data    = '0;
          nonempty_d = 1'b1;
        end else begin
          wr_data = top_bit_i ? {fresh, {IdxW{1'b0}}} : {{IdxW{1'b0}}, fresh};
          node_d  = fresh;
          used_d  = used_q + CntW'(1);
          lvl_d   = lvl_q + LvlW'(1);
          shift_o = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy_o   = state_q != ST_IDLE;
  assign done_o   = state_q == ST_DONE;
  assign best_o   = best_q;
  assign status_o = stat_q;

endmodule
`default_nettype wire

FILE: design/binary_trie_max_xor_unit.sv
// Timing: a query or a repeated insert shows its result once the walk has passed every
// trie level, an insert that adds nodes once it has also written the leaf entry; one
// node-table access per trie level. A refused insert answers before its walk ends,
// and a query on an empty set in the very next cycle. Only one request is taken at a
// time, accepted the cycle after the result is taken.
// Reset: asynchronous, active low; the set is empty and only the root node exists.
`timescale 1ns / 1ps
`default_nettype none
module binary_trie_max_xor_unit
  import btmx_pkg::*;
#(
  parameter int unsigned KEY_BITS  = 40,
  parameter int unsigned MAX_NODES = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // key
  input  wire         s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // best_xor, status, zero padding
  output logic        m_axis_tuser
);

  logic                accept;
  logic                shift;
  logic                busy;
  logic                done;
  logic                top_bit;
  logic [KEY_BITS-1:0] best;
  logic [KEY_BITS:0]   chain;
  status_e             status;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Cells shift the key up so the current level's bit sits at the top.
  assign chain[0] = 1'b0;
  for (genvar g = 0; g < KEY_BITS; g++) begin : g_cell
    btmx_level_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (accept),
      .shift_i    (shift),
      .load_bit_i (g < KeyFieldBits ? s_axis_tdata[g % KeyFieldBits] : 1'b0),
      .prev_bit_i (chain[g]),
      .bit_o      (chain[g+1])
    );
  end

  assign top_bit = chain[KEY_BITS];

  btmx_walker #(
    .KEY_BITS  (KEY_BITS),
    .MAX_NODES (MAX_NODES)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .action_i  (s_axis_tuser),
    .top_bit_i (top_bit),
    .shift_o   (shift),
    .busy_o    (busy),
    .done_o    (done),
    .best_o    (best),
    .status_o  (status),
    .take_i    (m_axis_tready)
  );

  assign m_axis_tvalid = done;
  assign m_axis_tuser  = 1'b0;
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[39:0]  = 40'(best);
    m_axis_tdata[41:40] = status;
  end

endmodule
`default_nettype wire

FILE: design/btmx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module btmx_assertions
  import btmx_pkg::*;
(
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [47:0] m_axis_tdata
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[41:40] <= STATUS_EMPTY)
    else $error("invalid status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[41:40] != STATUS_OK |-> m_axis_tdata[39:0] == 40'd0)
    else $error("non-zero result with error status");

endmodule

bind binary_trie_max_xor_unit btmx_assertions u_btmx_assertions (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
